### design/sync_length_xor_frame_receiver_assert.svh
// Assertion macros for the frame receiver.
// Each macro checks on the rising edge of clk_i and is held off while rst_ni is low.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define SXFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SXFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SXFR_ASSERT(lbl, prop, msg)
`define SXFR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### design/sxfr_pkg.sv
// Shared types and constants for the sync/length/XOR frame receiver.
// No dependencies.
package sxfr_pkg;

  localparam int unsigned MaxPayload = 32;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned LenW       = $clog2(MaxPayload + 1);
  localparam int unsigned FrameLenW  = 6;
  localparam int unsigned ByteIdxW   = 5;

  localparam logic [7:0] SyncFirst     = 8'hAA;
  localparam logic [7:0] SyncSecond    = 8'h55;
  localparam logic [7:0] EnableTypeRst = 8'h11;

  // Register map, word index
  localparam logic [1:0] RegEnableType = 2'd0;

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhSync2  = 3'd1,
    PhType   = 3'd2,
    PhLenHi  = 3'd3,
    PhLenLo  = 3'd4,
    PhData   = 3'd5,
    PhCheck  = 3'd6,
    PhEmit   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0]           frame_type;
    logic [FrameLenW-1:0] frame_len;
    logic [ByteIdxW-1:0]  byte_index;
    logic [7:0]           payload_byte;
    logic                 payload_valid;
    logic                 last;
    logic [7:0]           enable_mask;
  } result_t;

endpackage

### design/sxfr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone, no package dependency.
module sxfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sxfr_core.sv
// Frame parser and result sequencer; stores payload bytes in the RAM, reads them back.
// Depends on sxfr_pkg and the assertion macro header.
`include "sync_length_xor_frame_receiver_assert.svh"

module sxfr_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  input  logic [7:0]             enable_msg_type_i,
  output logic                   ram_we_o,
  output logic [sxfr_pkg::AddrW-1:0] ram_waddr_o,
  output logic [7:0]             ram_wdata_o,
  output logic                   ram_re_o,
  output logic [sxfr_pkg::AddrW-1:0] ram_raddr_o,
  input  logic [7:0]             ram_rdata_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sxfr_pkg::result_t      out_o
);

  sxfr_pkg::phase_e state_q, state_d;
  logic [7:0]                  type_q, type_d;
  logic [7:0]                  lenhi_q, lenhi_d;
  logic [sxfr_pkg::LenW-1:0]   len_q, len_d;
  logic [sxfr_pkg::LenW-1:0]   cnt_q, cnt_d;
  logic [sxfr_pkg::LenW-1:0]   rd_idx_q, rd_idx_d;
  logic [7:0]                  xor_q, xor_d;
  logic [7:0]                  mask_q, mask_d;
  logic                        ld_mask_q, ld_mask_d;
  logic                        pend_q, pend_d;
  logic [sxfr_pkg::AddrW-1:0]  pend_idx_q, pend_idx_d;
  logic                        pend_last_q, pend_last_d;
  logic                        out_valid_q, out_valid_d;
  sxfr_pkg::result_t           out_q, out_d;

  logic        in_acc, out_acc, out_free;
  logic [15:0] full_len;
  logic [7:0]  mask_new;
  logic [sxfr_pkg::LenW-1:0] cnt_inc, rd_inc;

  assign in_stall_o = (state_q == sxfr_pkg::PhEmit);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full_len   = {lenhi_q, rx_byte_i};
  assign cnt_inc    = cnt_q + 1'b1;
  assign rd_inc     = rd_idx_q + 1'b1;
  assign mask_new   = (ld_mask_q && (pend_idx_q == '0)) ? ram_rdata_i : mask_q;

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    lenhi_d     = lenhi_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    xor_d       = xor_q;
    mask_d      = mask_q;
    ld_mask_d   = ld_mask_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[sxfr_pkg::AddrW-1:0];
    ram_wdata_o = rx_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_idx_q[sxfr_pkg::AddrW-1:0];

    case (state_q)
      sxfr_pkg::PhSync2: begin
        if (in_acc) begin
          state_d = (rx_byte_i == sxfr_pkg::SyncSecond) ? sxfr_pkg::PhType : sxfr_pkg::PhHunt;
        end
      end
      sxfr_pkg::PhType: begin
        if (in_acc) begin
          type_d  = rx_byte_i;
          xor_d   = rx_byte_i;
          state_d = sxfr_pkg::PhLenHi;
        end
      end
      sxfr_pkg::PhLenHi: begin
        if (in_acc) begin
          lenhi_d = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          state_d = sxfr_pkg::PhLenLo;
        end
      end
      sxfr_pkg::PhLenLo: begin
        if (in_acc) begin
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = '0;
          len_d = full_len[sxfr_pkg::LenW-1:0];
          if (full_len == 16'd0) begin
            state_d = sxfr_pkg::PhCheck;
          end else if (full_len <= 16'(sxfr_pkg::MaxPayload)) begin
            state_d = sxfr_pkg::PhData;
          end else begin
            // oversize: drop silently
            state_d = sxfr_pkg::PhHunt;
          end
        end
      end
      sxfr_pkg::PhData: begin
        if (in_acc) begin
          ram_we_o = 1'b1;
          cnt_d    = cnt_inc;
          xor_d    = xor_q ^ rx_byte_i;
          if (cnt_inc == len_q) begin
            state_d = sxfr_pkg::PhCheck;
          end
        end
      end
      sxfr_pkg::PhCheck: begin
        if (in_acc) begin
          if (rx_byte_i == xor_q) begin
            ld_mask_d = (type_q == enable_msg_type_i) && (len_q != '0);
            rd_idx_d  = '0;
            state_d   = sxfr_pkg::PhEmit;
          end else begin
            state_d = sxfr_pkg::PhHunt;
          end
        end
      end
      sxfr_pkg::PhEmit: begin
        if (len_q == '0) begin
          // empty frame: one result straight from the registers
          if (out_free) begin
            out_valid_d         = 1'b1;
            out_d.frame_type    = type_q;
            out_d.frame_len     = '0;
            out_d.byte_index    = '0;
            out_d.payload_byte  = '0;
            out_d.payload_valid = 1'b0;
            out_d.last          = 1'b1;
            out_d.enable_mask   = mask_q;
            state_d             = sxfr_pkg::PhHunt;
          end
        end else begin
          if (!pend_q && out_free && (rd_idx_q < len_q)) begin
            ram_re_o    = 1'b1;
            rd_idx_d    = rd_inc;
            pend_d      = 1'b1;
            pend_idx_d  = rd_idx_q[sxfr_pkg::AddrW-1:0];
            pend_last_d = (rd_inc == len_q);
          end
          if (pend_q) begin
            mask_d              = mask_new;
            out_valid_d         = 1'b1;
            out_d.frame_type    = type_q;
            out_d.frame_len     = sxfr_pkg::FrameLenW'(len_q);
            out_d.byte_index    = sxfr_pkg::ByteIdxW'(pend_idx_q);
            out_d.payload_byte  = ram_rdata_i;
            out_d.payload_valid = 1'b1;
            out_d.last          = pend_last_q;
            out_d.enable_mask   = mask_new;
            if (pend_last_q) begin
              state_d = sxfr_pkg::PhHunt;
            end
          end
        end
      end
      default: begin
        if (in_acc) begin
          state_d = (rx_byte_i == sxfr_pkg::SyncFirst) ? sxfr_pkg::PhSync2 : sxfr_pkg::PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sxfr_pkg::PhHunt;
      type_q      <= '0;
      lenhi_q     <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      xor_q       <= '0;
      mask_q      <= '0;
      ld_mask_q   <= 1'b0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      lenhi_q     <= lenhi_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      xor_q       <= xor_d;
      mask_q      <= mask_d;
      ld_mask_q   <= ld_mask_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SXFR_ASSERT_IMPL(a_pend_slot_free, pend_q, !out_valid_q, "read data arrives with output slot full")
  `SXFR_ASSERT_IMPL(a_no_read_overlap, ram_re_o, !pend_q, "RAM read issued while one is pending")
  `SXFR_ASSERT_IMPL(a_data_in_range, in_acc && (state_q == sxfr_pkg::PhData), cnt_q < len_q, "payload byte beyond frame length")
  `SXFR_ASSERT_IMPL(a_no_write_in_emit, state_q == sxfr_pkg::PhEmit, !ram_we_o, "RAM written during result readout")
  `SXFR_ASSERT_IMPL(a_last_index, out_valid_q && out_q.last && out_q.payload_valid, (6'(out_q.byte_index) + 6'd1) == out_q.frame_len, "last flag on wrong byte")

endmodule

### design/sync_length_xor_frame_receiver.sv
// Top level of the sync/length/XOR frame receiver: APB register, parser core, payload RAM.
// Depends on sxfr_pkg, sxfr_core and sxfr_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid_i / in_stall_o   | rx_byte_i
//   output   | out_valid_o / out_stall_i | frame_type_o .. enable_mask_o (seven fields)
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// Parsing takes one cycle per received byte while in_stall_o is low; the payload is written to
// the RAM as it arrives. After a matching checksum the input is stalled while results are read
// via the single registered read port; a read waits until the previous byte is registered.
// A zero-length frame's one result needs no RAM read. Reset clears all control state and the
// enable mask; the RAM is not cleared, as a byte is only read after it is written in its frame.
// A stalled result holds in the output register while parsing of the next frame carries on.
module sync_length_xor_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_type_o,
  output logic [5:0]  frame_len_o,
  output logic [4:0]  byte_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic        last_o,
  output logic [7:0]  enable_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]                 enable_type_q;
  logic                       ram_we, ram_re;
  logic [sxfr_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata;
  sxfr_pkg::result_t          res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_type_q <= sxfr_pkg::EnableTypeRst;
    end else if (psel && penable && pwrite && (paddr[3:2] == sxfr_pkg::RegEnableType)) begin
      enable_type_q <= pwdata[7:0];
    end
  end

  always_comb begin
    case (paddr[3:2])
      sxfr_pkg::RegEnableType: prdata = {24'd0, enable_type_q};
      default:                 prdata = '0;
    endcase
  end

  sxfr_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .enable_msg_type_i (enable_type_q),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_o             (res)
  );

  sxfr_ram #(
    .Width (8),
    .Depth (sxfr_pkg::MaxPayload)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign frame_type_o    = res.frame_type;
  assign frame_len_o     = res.frame_len;
  assign byte_index_o    = res.byte_index;
  assign payload_byte_o  = res.payload_byte;
  assign payload_valid_o = res.payload_valid;
  assign last_o          = res.last;
  assign enable_mask_o   = res.enable_mask;

endmodule
